// ===== rtl/core/srl_pkg.sv =====
// Shared types and constants for the two-axis s-curve rate limiter.
// Used by srl_axis, srl_merge and two_axis_scurve_rate_limiter; no dependencies.
package srl_pkg;

    localparam int ANGLE_W = 32;
    localparam int PHASE_W = 17;
    localparam int LIMIT_W = 31;
    localparam int CFG_ADDR_W = 2;

    localparam logic [PHASE_W-1:0] PHASE_ONE = 17'd65536;
    // 3.0 in Q2.16 for the factor 3 - 2p of the smoothstep
    localparam logic [17:0] SMOOTH_K = 18'd196608;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 17'd1311;
    localparam logic [LIMIT_W-1:0] MAX_STEP_RESET = 31'd2359296;

    localparam logic [CFG_ADDR_W-1:0] CFG_PHASE_STEP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_YAW_STEP = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PITCH_STEP = 2'd2;

    typedef enum logic [3:0] {
        LN_IDLE,
        LN_PHASE,
        LN_SQUARE,
        LN_SMOOTH,
        LN_SHAPE,
        LN_SCALE,
        LN_ROUND,
        LN_CLAMP,
        LN_UPDATE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic target;
        logic advance;
    } lane_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } lane_stat_t;

endpackage

// ===== rtl/core/srl_axis.sv =====
// One axis lane: phase update, smoothstep, scaled profile, clamp and saturate.
// One shared 33x18 multiplier sequenced by a state machine. Depends on srl_pkg.
module srl_axis (
    input  logic                                clk,
    input  logic                                rst_n,
    input  srl_pkg::lane_ctrl_t                 ctrl,
    input  logic signed [srl_pkg::ANGLE_W-1:0]  goal,
    input  logic        [srl_pkg::PHASE_W-1:0]  phase_step,
    input  logic        [srl_pkg::LIMIT_W-1:0]  limit,
    output srl_pkg::lane_stat_t                 status,
    output logic signed [srl_pkg::ANGLE_W-1:0]  angle
);
    import srl_pkg::*;

    lane_state_t state_reg, state_next;

    logic signed [31:0] now_reg;
    logic signed [31:0] goal_reg;
    logic signed [31:0] origin_reg;
    logic [16:0]        phase_reg;
    logic [50:0]        prod_reg;
    logic [16:0]        s_reg;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic signed [33:0] prof_reg;
    logic signed [31:0] step_reg;

    logic [32:0] mul_a;
    logic [17:0] mul_b;
    logic [50:0] product;

    logic [17:0]        phase_sum;
    logic signed [32:0] delta;
    logic [50:0]        shape_sum;
    logic [50:0]        round_sum;
    logic [32:0]        rounded;
    logic signed [32:0] progress;
    logic signed [34:0] step_raw;
    logic signed [34:0] lim_pos;
    logic signed [34:0] lim_neg;
    logic signed [34:0] step_clamped;
    logic signed [32:0] angle_sum;

    assign product = {18'b0, mul_a} * {33'b0, mul_b};

    assign phase_sum = {1'b0, phase_reg} + {1'b0, phase_step};
    assign delta = {goal_reg[31], goal_reg} - {origin_reg[31], origin_reg};
    assign shape_sum = prod_reg + 51'h0_8000_0000;
    assign round_sum = prod_reg + 51'd32768;
    assign rounded = round_sum[48:16];
    assign progress = {now_reg[31], now_reg} - {origin_reg[31], origin_reg};
    assign step_raw = {prof_reg[33], prof_reg} - {{2{progress[32]}}, progress};
    assign lim_pos = $signed({4'b0, limit});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (step_raw > lim_pos)
        begin
            step_clamped = lim_pos;
        end
        else if (step_raw < lim_neg)
        begin
            step_clamped = lim_neg;
        end
        else
        begin
            step_clamped = step_raw;
        end
    end

    assign angle_sum = {now_reg[31], now_reg} + {step_reg[31], step_reg};

    always_comb
    begin
        if (angle_sum[32] != angle_sum[31])
        begin
            angle = angle_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            angle = angle_sum[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LN_IDLE:
            begin
                if (ctrl.start && !ctrl.target)
                begin
                    state_next = LN_PHASE;
                end
            end
            LN_PHASE:  state_next = LN_SQUARE;
            LN_SQUARE: state_next = LN_SMOOTH;
            LN_SMOOTH: state_next = LN_SHAPE;
            LN_SHAPE:  state_next = LN_SCALE;
            LN_SCALE:  state_next = LN_ROUND;
            LN_ROUND:  state_next = LN_CLAMP;
            LN_CLAMP:  state_next = LN_UPDATE;
            LN_UPDATE:
            begin
                if (ctrl.advance)
                begin
                    state_next = LN_IDLE;
                end
            end
            default:   state_next = LN_IDLE;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            LN_SQUARE:
            begin
                mul_a = {16'b0, phase_reg};
                mul_b = {1'b0, phase_reg};
            end
            LN_SMOOTH:
            begin
                mul_a = prod_reg[32:0];
                mul_b = SMOOTH_K - {phase_reg, 1'b0};
            end
            LN_SCALE:
            begin
                mul_a = mag_reg;
                mul_b = {1'b0, s_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        status.busy = (state_reg != LN_IDLE);
        status.done = (state_reg == LN_UPDATE) && ctrl.advance;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            now_reg <= '0;
            goal_reg <= '0;
            origin_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == LN_IDLE && ctrl.start && ctrl.target)
            begin
                goal_reg <= goal;
                origin_reg <= now_reg;
                phase_reg <= '0;
            end
            if (state_reg == LN_PHASE)
            begin
                if (now_reg != goal_reg)
                begin
                    phase_reg <= (phase_sum > {1'b0, PHASE_ONE}) ? PHASE_ONE
                                                                 : phase_sum[16:0];
                end
                else
                begin
                    phase_reg <= '0;
                    origin_reg <= now_reg;
                end
            end
            if (state_reg == LN_UPDATE && ctrl.advance)
            begin
                now_reg <= angle;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            LN_SQUARE:
            begin
                prod_reg <= product;
                neg_reg <= delta[32];
                mag_reg <= delta[32] ? 33'(-delta) : 33'(delta);
            end
            LN_SMOOTH: prod_reg <= product;
            LN_SHAPE:  s_reg <= shape_sum[48:32];
            LN_SCALE:  prod_reg <= product;
            LN_ROUND:  prof_reg <= neg_reg ? -$signed({1'b0, rounded})
                                           : $signed({1'b0, rounded});
            LN_CLAMP:  step_reg <= step_clamped[31:0];
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_ONE)
        else $error("phase above one");

    a_shape_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LN_SHAPE) |=> (s_reg <= PHASE_ONE))
        else $error("smoothstep value above one");

    a_step_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LN_UPDATE) |->
            (step_reg <= $signed({1'b0, limit})) && (step_reg >= -$signed({1'b0, limit})))
        else $error("step beyond axis limit");
`endif

endmodule

// ===== rtl/core/srl_merge.sv =====
// Merge stage: joins the yaw and pitch lane results into one output word.
// Holds the word until taken and tells the lanes when they may commit. Uses srl_pkg.
module srl_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic signed [srl_pkg::ANGLE_W-1:0]  yaw_angle,
    input  logic signed [srl_pkg::ANGLE_W-1:0]  pitch_angle,
    output logic                                advance,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*srl_pkg::ANGLE_W-1:0]       m_axis_tdata   // yaw_angle, pitch_angle
);
    import srl_pkg::*;

    logic                     valid_reg, valid_next;
    logic [2*ANGLE_W-1:0]     data_reg;

    assign advance = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {pitch_angle, yaw_angle};
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata = data_reg;

endmodule

// ===== rtl/core/two_axis_scurve_rate_limiter.sv =====
// Two-axis s-curve rate limiter: config registers, two axis lanes and merge stage.
// Depends on srl_pkg, srl_axis and srl_merge.
//
// A target word (tuser = 1) stores new yaw and pitch goals and gives
// no output; the block is ready again the next cycle. A tick word (tuser = 0) runs
// both axis lanes side by side through an eight-state sequence around one shared
// 33x18 multiplier per lane (phase, square, cube term, shape, scale, round, clamp,
// update), and a new word is taken only once both lanes are back in idle after the
// update step. The output register holds the result while the next word is
// accepted; a tick stalls at its update step only while the previous output word
// is still waiting. Angles are Q15.16 degrees.
module two_axis_scurve_rate_limiter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [srl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [srl_pkg::LIMIT_W-1:0]       cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [63:0]                       s_axis_tdata,   // goal_yaw, goal_pitch
    input  logic [0:0]                        s_axis_tuser,   // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata    // yaw_angle, pitch_angle
);
    import srl_pkg::*;

    logic [PHASE_W-1:0] phase_step_reg;
    logic [LIMIT_W-1:0] max_yaw_step_reg;
    logic [LIMIT_W-1:0] max_pitch_step_reg;

    lane_ctrl_t lane_ctrl;
    lane_stat_t yaw_stat;
    lane_stat_t pitch_stat;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic advance;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= PHASE_STEP_RESET;
            max_yaw_step_reg <= MAX_STEP_RESET;
            max_pitch_step_reg <= MAX_STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PHASE_STEP:     phase_step_reg <= cfg_wdata[PHASE_W-1:0];
                CFG_MAX_YAW_STEP:   max_yaw_step_reg <= cfg_wdata;
                CFG_MAX_PITCH_STEP: max_pitch_step_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = !yaw_stat.busy && !pitch_stat.busy;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign lane_ctrl.start = accept;
    assign lane_ctrl.target = s_axis_tuser[0];
    assign lane_ctrl.advance = advance;

    srl_axis u_yaw (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .goal       ($signed(s_axis_tdata[31:0])),
        .phase_step (phase_step_reg),
        .limit      (max_yaw_step_reg),
        .status     (yaw_stat),
        .angle      (yaw_angle)
    );

    srl_axis u_pitch (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .goal       ($signed(s_axis_tdata[63:32])),
        .phase_step (phase_step_reg),
        .limit      (max_pitch_step_reg),
        .status     (pitch_stat),
        .angle      (pitch_angle)
    );

    srl_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (yaw_stat.done && pitch_stat.done),
        .yaw_angle     (yaw_angle),
        .pitch_angle   (pitch_angle),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTH
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (yaw_stat.done == pitch_stat.done) && (yaw_stat.busy == pitch_stat.busy))
        else $error("axis lanes out of step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        yaw_stat.done |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a waiting word");

    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !s_axis_tuser[0]) |=> (yaw_stat.busy && !s_axis_tready))
        else $error("tick accepted but lanes idle");
`endif

endmodule
